/* design/fpd_pkg.sv */
// Shared constants, types and the cell record of the fixed-point divider.
package fpd_pkg;

    // Operand and quotient width, and the width of the fraction-bit register.
    localparam int WIDTH     = 32;
    localparam int FRAC_W    = 5;
    localparam int NUM_CELLS = WIDTH;

    typedef logic [WIDTH-1:0]  t_word;
    typedef logic [FRAC_W-1:0] t_frac;

    localparam t_frac FRAC_RESET = t_frac'(8);

    // Data that one divider cell holds and hands to the next cell.
    typedef struct packed {
        t_word rem;
        t_word q;
        t_word div;
        logic  coarse;
        logic  dbz;
        t_frac shift;
    } t_cell;

    // One result beat.
    typedef struct packed {
        t_word quotient;
        logic  coarse_path;
        logic  divide_by_zero;
    } t_result;

endpackage

/* design/fpd_in_if.sv */
// Operand channel: valid, ready and the dividend and divisor of one beat.
interface fpd_in_if;
    logic          valid;
    logic          ready;
    fpd_pkg::t_word dividend;
    fpd_pkg::t_word divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

/* design/fpd_out_if.sv */
// Result channel: valid, ready and the quotient and flags of one beat.
interface fpd_out_if;
    logic          valid;
    logic          ready;
    fpd_pkg::t_word quotient;
    logic          coarse_path;
    logic          divide_by_zero;

    modport source (output valid, output quotient, output coarse_path,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input quotient, input coarse_path,
                    input divide_by_zero, output ready);
endinterface

/* design/fixed_point_divider_top.sv */
// Top level of the pipelined unsigned fixed-point divider.
//
//   Channel   Dir  Handshake          Payload
//   i_in      in   valid / ready      dividend[31:0], divisor[31:0]
//   o_out     out  valid / ready      quotient[31:0], coarse_path, divide_by_zero
//   i_cfg     in   write enable only  frac_bits[4:0]
//
// One beat is accepted per cycle while i_in.ready is high; each result passes the
// entry stage, one cell per quotient bit for 32 bits, and the output register.
// The chain holds 32 restoring-division cells.
// Reset clears all valid flags and loads frac_bits with 8; there is no clearing pass.
// A stalled output parks one beat in a skid register; while it is full the whole
// chain holds and i_in.ready is low.
module fixed_point_divider_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  fpd_pkg::t_frac i_cfg_wdata,
    fpd_in_if.sink         i_in,
    fpd_out_if.source      o_out
);

    fpd_pkg::t_frac       r_frac_bits;
    logic                 w_en;
    logic                 w_valid [0:fpd_pkg::NUM_CELLS];
    fpd_pkg::t_cell       w_cell  [0:fpd_pkg::NUM_CELLS];
    fpd_pkg::t_result     w_result;

    // Fraction-bit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= fpd_pkg::FRAC_RESET;
        end else begin
            if (i_cfg_we) begin
                r_frac_bits <= i_cfg_wdata;
            end
        end
    end

    assign i_in.ready = w_en;

    // Entry stage.
    fpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in.valid),
        .i_dividend  (i_in.dividend),
        .i_divisor   (i_in.divisor),
        .i_frac_bits (r_frac_bits),
        .o_valid     (w_valid[0]),
        .o_cell      (w_cell[0])
    );

    // Chain of division cells, one quotient bit each.
    for (genvar g = 0; g < fpd_pkg::NUM_CELLS; g++) begin : g_cell
        fpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_cell  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    // Exit stage with output and skid registers.
    fpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[fpd_pkg::NUM_CELLS]),
        .i_cell   (w_cell[fpd_pkg::NUM_CELLS]),
        .i_ready  (o_out.ready),
        .o_en     (w_en),
        .o_valid  (o_out.valid),
        .o_result (w_result)
    );

    assign o_out.quotient       = w_result.quotient;
    assign o_out.coarse_path    = w_result.coarse_path;
    assign o_out.divide_by_zero = w_result.divide_by_zero;

endmodule

/* design/fpd_front.sv */
// Entry stage: picks the fine or coarse path and registers the numerator.
module fpd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  fpd_pkg::t_word i_dividend,
    input  fpd_pkg::t_word i_divisor,
    input  fpd_pkg::t_frac i_frac_bits,
    output logic           o_valid,
    output fpd_pkg::t_cell o_cell
);

    logic [2*fpd_pkg::WIDTH-1:0] w_wide;
    logic                        w_fine;
    logic                        w_dbz;
    fpd_pkg::t_cell              n_cell;
    logic                        r_valid;
    fpd_pkg::t_cell              r_cell;

    // The pre-shift is safe when no dividend bit leaves the word.
    always_comb begin
        w_wide = {{fpd_pkg::WIDTH{1'b0}}, i_dividend} << i_frac_bits;
        w_fine = (w_wide[2*fpd_pkg::WIDTH-1:fpd_pkg::WIDTH] == '0);
        w_dbz  = (i_divisor == '0);

        n_cell.rem    = '0;
        n_cell.q      = w_fine ? w_wide[fpd_pkg::WIDTH-1:0] : i_dividend;
        n_cell.div    = i_divisor;
        n_cell.dbz    = w_dbz;
        n_cell.coarse = !w_dbz && !w_fine;
        n_cell.shift  = w_fine ? '0 : i_frac_bits;
    end

    // Valid flag of the entry stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload of the entry stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

/* design/fpd_cell.sv */
// One restoring division step: brings down a numerator bit, yields a quotient bit.
module fpd_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  fpd_pkg::t_cell i_cell,
    output logic           o_valid,
    output fpd_pkg::t_cell o_cell
);

    logic [fpd_pkg::WIDTH:0] w_trial;
    logic [fpd_pkg::WIDTH:0] w_diff;
    logic                    w_ge;
    fpd_pkg::t_cell          n_cell;
    logic                    r_valid;
    fpd_pkg::t_cell          r_cell;

    // Shift the next numerator bit into the remainder and try the subtract.
    always_comb begin
        w_trial = {i_cell.rem, i_cell.q[fpd_pkg::WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_cell.div};
        w_ge    = !w_diff[fpd_pkg::WIDTH];

        n_cell     = i_cell;
        n_cell.rem = w_ge ? w_diff[fpd_pkg::WIDTH-1:0] : w_trial[fpd_pkg::WIDTH-1:0];
        n_cell.q   = {i_cell.q[fpd_pkg::WIDTH-2:0], w_ge};
    end

    // Valid flag of this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload of this cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

/* design/fpd_back.sv */
// Exit stage: applies the coarse shift and zero-divisor result, output and skid registers.
module fpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fpd_pkg::t_cell  i_cell,
    input  logic            i_ready,
    output logic            o_en,
    output logic            o_valid,
    output fpd_pkg::t_result o_result
);

    fpd_pkg::t_result n_res;
    logic             r_out_valid;
    logic             r_skid_valid;
    fpd_pkg::t_result r_out;
    fpd_pkg::t_result r_skid;

    // Final quotient from the last cell.
    always_comb begin
        if (i_cell.dbz) begin
            n_res.quotient = '1;
        end else if (i_cell.coarse) begin
            n_res.quotient = i_cell.q << i_cell.shift;
        end else begin
            n_res.quotient = i_cell.q;
        end
        n_res.coarse_path    = i_cell.coarse;
        n_res.divide_by_zero = i_cell.dbz;
    end

    // The chain moves whenever the skid register is free.
    assign o_en = !r_skid_valid;

    // Output and skid valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output and skid payload.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_out_valid || i_ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    // The skid register is only used behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while the output register is empty");

    // A beat in the skid register stays until the sink takes the output.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> r_skid_valid)
        else $error("skid beat dropped without a transfer");

    // A zero-divisor result is all ones and never marked coarse.
    a_dbz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.divide_by_zero) |->
            (r_out.quotient == '1 && !r_out.coarse_path))
        else $error("zero-divisor result malformed");
`endif

endmodule

/* test/tb_fixed_point_divider_top.sv */
// Self-checking testbench for the pipelined unsigned fixed-point divider.
module tb_fixed_point_divider_top;

    localparam int LATENCY        = 34;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 66;
    localparam int IDLE_PERCENT   = 16;

    // Holds the quotients still due from the divider and checks arrivals against them.
    class fpd_scoreboard;
        fpd_pkg::t_frac   frac_bits;
        fpd_pkg::t_result due_results[$];
        int               mismatches;

        function new();
            frac_bits  = fpd_pkg::FRAC_RESET;
            mismatches = 0;
        endfunction

        // Computes the quotient and flags for one operand pair at the current frac_bits.
        function fpd_pkg::t_result divide(fpd_pkg::t_word dividend, fpd_pkg::t_word divisor);
            fpd_pkg::t_result res;
            int unsigned      msb;
            logic [63:0]      wide;
            res = '0;
            msb = 0;
            if (divisor == '0) begin
                res.quotient       = '1;
                res.divide_by_zero = 1'b1;
            end else begin
                for (int i = 0; i < fpd_pkg::WIDTH; i++) begin
                    if (dividend[i]) msb = i;
                end
                // The fine path is safe only when the pre-shift keeps every dividend bit.
                if (msb + frac_bits < fpd_pkg::WIDTH) begin
                    wide         = {32'b0, dividend} << frac_bits;
                    res.quotient = fpd_pkg::t_word'(wide / {32'b0, divisor});
                end else begin
                    res.quotient    = fpd_pkg::t_word'((dividend / divisor) << frac_bits);
                    res.coarse_path = 1'b1;
                end
            end
            return res;
        endfunction

        function void note_operands(fpd_pkg::t_word dividend, fpd_pkg::t_word divisor);
            due_results.push_back(divide(dividend, divisor));
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        // Compares one result beat, field by field, with the oldest quotient due.
        task check_result(fpd_pkg::t_result got);
            fpd_pkg::t_result want;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result quotient=%h", got.quotient));
            end else begin
                want = due_results.pop_front();
                if (got.quotient !== want.quotient)
                    report($sformatf("quotient got %h want %h", got.quotient, want.quotient));
                if (got.coarse_path !== want.coarse_path)
                    report($sformatf("coarse_path got %b want %b",
                                     got.coarse_path, want.coarse_path));
                if (got.divide_by_zero !== want.divide_by_zero)
                    report($sformatf("divide_by_zero got %b want %b",
                                     got.divide_by_zero, want.divide_by_zero));
            end
        endtask
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    fpd_pkg::t_frac i_cfg_wdata;
    bit             steady;
    int             quiet_cycles = 0;

    fpd_in_if  in_ch();
    fpd_out_if out_ch();

    fpd_scoreboard sb = new();

    fixed_point_divider_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: check every accepted beat and stall at random.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            sb.check_result('{quotient: out_ch.quotient, coarse_path: out_ch.coarse_path,
                              divide_by_zero: out_ch.divide_by_zero});
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: give up when neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Random operand with a spread of magnitudes so both divide paths are hit.
    function fpd_pkg::t_word random_word();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom() >> $urandom_range(0, 31);
            2:       return $urandom_range(0, 255);
            3:       return fpd_pkg::t_word'(1) << $urandom_range(0, 31);
            4:       return '1;
            default: return $urandom() >> $urandom_range(8, 24);
        endcase
    endfunction

    // Offers one operand beat, after a random gap, and waits until it is taken.
    task send(fpd_pkg::t_word dividend, fpd_pkg::t_word divisor);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.dividend <= dividend;
        in_ch.divisor  <= divisor;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_operands(dividend, divisor);
    endtask

    // Stops offering beats and waits until every quotient due has arrived.
    task drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task write_frac(fpd_pkg::t_frac value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.frac_bits = value;
    endtask

    task send_random(int count);
        fpd_pkg::t_word divisor;
        for (int n = 0; n < count; n++) begin
            divisor = ($urandom_range(0, 99) < 6) ? fpd_pkg::t_word'(0) : random_word();
            send(random_word(), divisor);
        end
    endtask

    // Stimulus: directed corners at the reset setting, then sets of random operands at several frac_bits settings.
    initial begin
        fpd_pkg::t_word dir_a [19];
        fpd_pkg::t_word dir_b [19];
        fpd_pkg::t_frac settings [8];
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.dividend <= '0;
        in_ch.divisor  <= '0;
        steady         = 1'b0;
        dir_a = '{32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1,
                  32'h00FFFFFF, 32'h01000000, 32'h80000000, 32'h100, 32'h300, 32'h1,
                  32'd12345678, 32'h00800000, 32'hAAAAAAAA, 32'h55555555, 32'h1,
                  32'hFFFFFFFF, 32'h007FFFFF};
        dir_b = '{32'h0, 32'h1, 32'h0, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'h1, 32'h1, 32'h3, 32'h100, 32'h200, 32'h1,
                  32'h7, 32'h1, 32'h55555555, 32'hAAAAAAAA, 32'h0,
                  32'h80000000, 32'hFFFFFFFF};
        settings = '{fpd_pkg::t_frac'(0), fpd_pkg::t_frac'(31), fpd_pkg::t_frac'(1),
                     fpd_pkg::t_frac'(16), fpd_pkg::t_frac'($urandom_range(0, 31)),
                     fpd_pkg::t_frac'(24), fpd_pkg::t_frac'($urandom_range(0, 31)),
                     fpd_pkg::t_frac'(8)};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corners of both operands, zero divisor and zero dividend, both paths.
        foreach (dir_a[k]) send(dir_a[k], dir_b[k]);

        foreach (settings[s]) begin
            drain();
            write_frac(settings[s]);
            // One whole set runs with both sides streaming, no gaps or stalls.
            steady = (s == 3);
            if (s == 2) begin
                send_random(ITEMS_PER_SET / 2);
                drain();
                send_random(ITEMS_PER_SET / 2);
            end else begin
                send_random(ITEMS_PER_SET);
            end
        end

        steady = 1'b0;
        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
